// ----- rtl/hgpl_pkg.sv -----
// ---------------------------------------------------------------------------
// hgpl_pkg: shared types and constants for the hex grid point locator
// grid size, table depths, register indexes and sequencer states
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package hgpl_pkg;

  // grid size and walk limit
  localparam int CELLS_X        = 16;
  localparam int CELLS_Y        = 16;
  localparam int CELLS_Z        = 16;
  localparam int MAX_WALK_STEPS = 64;

  localparam int NCELLS   = CELLS_X * CELLS_Y * CELLS_Z;
  localparam int YZ_COUNT = NCELLS + CELLS_Y * CELLS_Z;
  localparam int XZ_COUNT = NCELLS + CELLS_X * CELLS_Z;
  localparam int XY_COUNT = NCELLS + CELLS_X * CELLS_Y;
  localparam int MAX_COUNT_XY = (YZ_COUNT > XZ_COUNT) ? YZ_COUNT : XZ_COUNT;
  localparam int MAX_COUNT = (MAX_COUNT_XY > XY_COUNT) ? MAX_COUNT_XY : XY_COUNT;

  // widths
  localparam int PLANE_W = $clog2(MAX_COUNT);
  localparam int ADDR_W  = PLANE_W + 2;
  localparam int XC_W    = $clog2(CELLS_X);
  localparam int YC_W    = $clog2(CELLS_Y);
  localparam int ZC_W    = $clog2(CELLS_Z);
  localparam int CELL_W  = $clog2(NCELLS + 1);
  localparam int STEP_W  = $clog2(MAX_WALK_STEPS + 1);
  localparam int ACC_W   = 68;
  localparam int PROD_W  = 66;

  // field widths
  localparam int COORD_W  = 32;
  localparam int CIDX_W   = 12;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z    = 3'd5;

  // request kinds and tables
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOCATE = 1'b1;
  localparam logic [1:0] TBL_YZ = 2'd0;
  localparam logic [1:0] TBL_XZ = 2'd1;
  localparam logic [1:0] TBL_XY = 2'd2;
  localparam logic [1:0] WORD_OFFSET = 2'd3;
  localparam logic [31:0] OFFSET_SCALE = 32'd65536;

  // violated face
  typedef enum logic [2:0] {
    SIDE_NONE, SIDE_XMIN, SIDE_XMAX, SIDE_YMIN, SIDE_YMAX, SIDE_ZMIN, SIDE_ZMAX
  } side_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE, ST_GMUL, ST_GCHK, ST_WALK, ST_DECIDE, ST_DONE
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/hex_grid_point_locate_walk_top.sv -----
// ---------------------------------------------------------------------------
// hex_grid_point_locate_walk_top: point location in a deformed hex grid
// face plane tables, cell guess and face walk on one shared multiplier
// ---------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o) takes load and locate requests.
//   a load writes one plane word into a table and gives no result. a locate
//   gives one result on the output channel
//   (out_valid_o / out_stall_i): cell_index, found and walk_limit_hit.
//   a locate first guesses the cell, one axis at a time through the
//   multiplier (ST_GMUL, ST_GCHK), then walks: each step reads the 24
//   plane words of the cell's six faces from the one read port of each
//   table through registered read, multiply and accumulate stages, and
//   ST_DECIDE picks the next cell; ST_DONE hands off the result, and the
//   next request can be taken once the result is in the output register.
//   in_stall_o is high while a locate is in work, and while a result waits
//   behind a stalled output register the next locate still runs but holds
//   its own result until the register frees.
//   reset clears control state and config registers (origin 0, reciprocal
//   1.0); the plane tables are not cleared and must be loaded before use.
//   configuration writes are taken at any time the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hex_grid_point_locate_walk_top (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [hgpl_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [31:0]                            cfg_data_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic                                   kind_i,
  input  wire logic [1:0]                             table_sel_i,
  input  wire logic [12:0]                            plane_index_i,
  input  wire logic [1:0]                             coef_sel_i,
  input  wire logic signed [31:0]                     coef_value_i,
  input  wire logic signed [31:0]                     pos_x_i,
  input  wire logic signed [31:0]                     pos_y_i,
  input  wire logic signed [31:0]                     pos_z_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [hgpl_pkg::CIDX_W-1:0]                 cell_index_o,
  output logic                                        found_o,
  output logic                                        walk_limit_hit_o
);
  import hgpl_pkg::*;

  // configuration registers
  logic signed [31:0] org_q [3];
  logic [31:0]        inv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      inv_q[0] <= OFFSET_SCALE;
      inv_q[1] <= OFFSET_SCALE;
      inv_q[2] <= OFFSET_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        CFG_INV_X:    inv_q[0] <= cfg_data_i;
        CFG_INV_Y:    inv_q[1] <= cfg_data_i;
        CFG_INV_Z:    inv_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic   accept;
  assign accept = in_valid_i && !in_stall_o;

  // sequencer registers
  logic [1:0]          axis_q;
  logic [4:0]          cnt_q;
  logic [STEP_W-1:0]   steps_q;
  logic [XC_W-1:0]     ex_q;
  logic [YC_W-1:0]     ey_q;
  logic [ZC_W-1:0]     ez_q;
  logic signed [31:0]  pos_q [3];
  logic                gneg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, best_q;
  side_e               side_q;
  logic                v1_q, v2_q;
  logic [4:0]          t1_q, t2_q;
  logic [CIDX_W-1:0]   res_cell_q;
  logic                res_found_q, res_limit_q;

  // load write decode
  logic [ADDR_W-1:0] waddr;
  logic we_yz, we_xz, we_xy, is_load;
  assign is_load = accept && (kind_i == KIND_LOAD);
  assign waddr   = ADDR_W'({plane_index_i, coef_sel_i});
  assign we_yz = is_load && (table_sel_i == TBL_YZ) && (32'(plane_index_i) < YZ_COUNT);
  assign we_xz = is_load && (table_sel_i == TBL_XZ) && (32'(plane_index_i) < XZ_COUNT);
  assign we_xy = is_load && (table_sel_i == TBL_XY) && (32'(plane_index_i) < XY_COUNT);

  // plane numbers of the current cell
  logic [PLANE_W-1:0] e_yz, e_xz, e_xy, plane_sel;
  assign e_yz = PLANE_W'(ex_q) * PLANE_W'(CELLS_Y * CELLS_Z)
              + PLANE_W'(ez_q) * PLANE_W'(CELLS_Y) + PLANE_W'(ey_q);
  assign e_xz = PLANE_W'(ey_q) * PLANE_W'(CELLS_X * CELLS_Z)
              + PLANE_W'(ez_q) * PLANE_W'(CELLS_X) + PLANE_W'(ex_q);
  assign e_xy = PLANE_W'(ez_q) * PLANE_W'(CELLS_X * CELLS_Y)
              + PLANE_W'(ey_q) * PLANE_W'(CELLS_X) + PLANE_W'(ex_q);

  // read address for the word being issued
  logic [2:0] iface;
  logic       issue;
  assign iface = cnt_q[4:2];
  assign issue = (state_q == ST_WALK) && (cnt_q < 5'd24);
  always_comb begin
    case (iface)
      3'd0:    plane_sel = e_yz;
      3'd1:    plane_sel = e_yz + PLANE_W'(CELLS_Y * CELLS_Z);
      3'd2:    plane_sel = e_xz;
      3'd3:    plane_sel = e_xz + PLANE_W'(CELLS_X * CELLS_Z);
      3'd4:    plane_sel = e_xy;
      default: plane_sel = e_xy + PLANE_W'(CELLS_X * CELLS_Y);
    endcase
  end
  logic [ADDR_W-1:0] raddr;
  assign raddr = {plane_sel, cnt_q[1:0]};

  // plane tables
  logic [31:0] yz_mem [YZ_COUNT*4];
  logic [31:0] xz_mem [XZ_COUNT*4];
  logic [31:0] xy_mem [XY_COUNT*4];
  logic [31:0] yz_rd_q, xz_rd_q, xy_rd_q;

  always_ff @(posedge clk_i) begin
    if (we_yz) yz_mem[waddr] <= coef_value_i;
    yz_rd_q <= yz_mem[raddr];
  end
  always_ff @(posedge clk_i) begin
    if (we_xz) xz_mem[waddr] <= coef_value_i;
    xz_rd_q <= xz_mem[raddr];
  end
  always_ff @(posedge clk_i) begin
    if (we_xy) xy_mem[waddr] <= coef_value_i;
    xy_rd_q <= xy_mem[raddr];
  end

  // shared multiplier operands
  logic signed [31:0] rd_sel;
  logic signed [33:0] diff;
  logic signed [32:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  always_comb begin
    case (t1_q[4:3])
      2'd0:    rd_sel = yz_rd_q;
      2'd1:    rd_sel = (t1_q[2:1] == 2'd2) ? xy_rd_q : xz_rd_q;
      default: rd_sel = xy_rd_q;
    endcase
    if (t1_q[4:2] == 3'd2 || t1_q[4:2] == 3'd3) rd_sel = xz_rd_q;
    if (t1_q[4:2] == 3'd4 || t1_q[4:2] == 3'd5) rd_sel = xy_rd_q;
    if (t1_q[4:2] == 3'd0 || t1_q[4:2] == 3'd1) rd_sel = yz_rd_q;
  end
  // point minus origin spans 32 bits plus sign
  assign diff = 34'(pos_q[axis_q]) - 34'(org_q[axis_q]);
  always_comb begin
    if (state_q == ST_GMUL) begin
      mul_a = {1'b0, diff[31:0]};
      mul_b = {1'b0, inv_q[axis_q]};
    end else begin
      mul_a = 33'(rd_sel);
      mul_b = (t1_q[1:0] == WORD_OFFSET) ? {1'b0, OFFSET_SCALE}
                                          : 33'(pos_q[t1_q[1:0]]);
    end
  end
  assign mul_p = mul_a * mul_b;

  // face violation of the word being retired
  logic signed [ACC_W-1:0] prod_ext, viol;
  assign prod_ext = ACC_W'(prod_q);
  assign viol = t2_q[2] ? (acc_q - prod_ext) : (prod_ext - acc_q);

  // guess check
  logic [31:0] q_hi;
  logic        gfail;
  assign q_hi = prod_q[63:32];
  always_comb begin
    case (axis_q)
      2'd0:    gfail = gneg_q || (q_hi >= 32'(CELLS_X));
      2'd1:    gfail = gneg_q || (q_hi >= 32'(CELLS_Y));
      default: gfail = gneg_q || (q_hi >= 32'(CELLS_Z));
    endcase
  end

  // step decision
  logic at_edge, limit_now;
  logic [CELL_W-1:0] cell_lin;
  assign cell_lin = CELL_W'(ex_q) + CELL_W'(ey_q) * CELL_W'(CELLS_X)
                  + CELL_W'(ez_q) * CELL_W'(CELLS_X * CELLS_Y);
  assign limit_now = (32'(steps_q) >= MAX_WALK_STEPS);
  always_comb begin
    case (side_q)
      SIDE_XMIN: at_edge = (ex_q == '0);
      SIDE_XMAX: at_edge = (32'(ex_q) == CELLS_X - 1);
      SIDE_YMIN: at_edge = (ey_q == '0);
      SIDE_YMAX: at_edge = (32'(ey_q) == CELLS_Y - 1);
      SIDE_ZMIN: at_edge = (ez_q == '0);
      SIDE_ZMAX: at_edge = (32'(ez_q) == CELLS_Z - 1);
      default:   at_edge = 1'b0;
    endcase
  end

  // next state
  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept && kind_i == KIND_LOCATE) state_d = ST_GMUL;
      ST_GMUL:   state_d = ST_GCHK;
      ST_GCHK: begin
        if (gfail) state_d = ST_DONE;
        else if (axis_q == 2'd2) state_d = ST_WALK;
        else state_d = ST_GMUL;
      end
      ST_WALK:   if (cnt_q == 5'd25) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (side_q == SIDE_NONE || limit_now || at_edge) state_d = ST_DONE;
        else state_d = ST_WALK;
      end
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      cnt_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (state_q == ST_WALK) cnt_q <= cnt_q + 5'd1;
      else cnt_q <= '0;
      if (state_q == ST_DONE && out_free) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    t1_q <= cnt_q;
    t2_q <= t1_q;
    if (state_q == ST_GMUL || v1_q) prod_q <= mul_p;
    if (state_q == ST_GMUL) gneg_q <= diff[33];
    if (v2_q) begin
      case (t2_q[1:0])
        2'd0:        acc_q <= prod_ext;
        WORD_OFFSET: begin
          if (viol > best_q) begin
            best_q <= viol;
            side_q <= side_e'(t2_q[4:2] + 3'd1);
          end
        end
        default:     acc_q <= acc_q + prod_ext;
      endcase
    end
    case (state_q)
      ST_IDLE: begin
        pos_q[0] <= pos_x_i;
        pos_q[1] <= pos_y_i;
        pos_q[2] <= pos_z_i;
        axis_q   <= '0;
        steps_q  <= '0;
        best_q   <= '0;
        side_q   <= SIDE_NONE;
      end
      ST_GCHK: begin
        res_cell_q  <= '0;
        res_found_q <= 1'b0;
        res_limit_q <= 1'b0;
        axis_q <= axis_q + 2'd1;
        case (axis_q)
          2'd0:    ex_q <= q_hi[XC_W-1:0];
          2'd1:    ey_q <= q_hi[YC_W-1:0];
          default: ez_q <= q_hi[ZC_W-1:0];
        endcase
      end
      ST_DECIDE: begin
        best_q <= '0;
        side_q <= SIDE_NONE;
        // cell reached when found or stopped at the limit, else none
        res_cell_q  <= (side_q == SIDE_NONE || limit_now) ? CIDX_W'(cell_lin) : '0;
        res_found_q <= (side_q == SIDE_NONE);
        res_limit_q <= (side_q != SIDE_NONE) && limit_now;
        if (side_q != SIDE_NONE && !limit_now && !at_edge) begin
          steps_q <= steps_q + STEP_W'(1);
          case (side_q)
            SIDE_XMIN: ex_q <= ex_q - XC_W'(1);
            SIDE_XMAX: ex_q <= ex_q + XC_W'(1);
            SIDE_YMIN: ey_q <= ey_q - YC_W'(1);
            SIDE_YMAX: ey_q <= ey_q + YC_W'(1);
            SIDE_ZMIN: ez_q <= ez_q - ZC_W'(1);
            default:   ez_q <= ez_q + ZC_W'(1);
          endcase
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cell_index_o     <= res_cell_q;
          found_o          <= res_found_q;
          walk_limit_hit_o <= res_limit_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/hgpl_checker.sv -----
// ---------------------------------------------------------------------------
// hgpl_checker: port level checks for the hex grid point locator
// result flag consistency, stalled result hold and request acceptance behavior
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module hgpl_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        kind_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [hgpl_pkg::CIDX_W-1:0] cell_index_o,
  input wire logic                        found_o,
  input wire logic                        walk_limit_hit_o
);
  import hgpl_pkg::*;

  // a located point never also reports the walk limit
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && walk_limit_hit_o))
    else $error("found and walk limit both set");

  // a locate request blocks the input channel on the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i == KIND_LOCATE) |=> in_stall_o)
    else $error("locate request did not hold off input");

  // a load request leaves the input channel open
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i == KIND_LOAD) |=> !in_stall_o)
    else $error("load request blocked input");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(cell_index_o) && $stable(found_o)))
    else $error("stalled result changed");

endmodule

bind hex_grid_point_locate_walk_top hgpl_checker u_hgpl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .kind_i           (kind_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .cell_index_o     (cell_index_o),
  .found_o          (found_o),
  .walk_limit_hit_o (walk_limit_hit_o)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// tb: testbench for the hex grid point locator
// fills a corner block of the three face plane tables with a jittered
// regular grid, then runs directed and random locate requests under several
// grid frames; a local walk predictor computes every expected result, only
// walks over loaded planes are sent, and a monitor compares the results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import hgpl_pkg::*;

  typedef struct packed {
    logic [CIDX_W-1:0] cell_index;
    logic              found;
    logic              walk_limit_hit;
  } locate_result_t;

  localparam int SETTLE_CYCLES = 60;
  localparam int YZ_STRIDE = CELLS_Y * CELLS_Z;
  localparam int XZ_STRIDE = CELLS_X * CELLS_Z;
  localparam int XY_STRIDE = CELLS_X * CELLS_Y;
  localparam int REGION = 4;
  localparam int DRAW_TRIES = 32;
  localparam logic signed [31:0] ONE = 32'sd65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = KIND_LOAD;
  logic [1:0] table_sel_i = TBL_YZ;
  logic [12:0] plane_index_i = '0;
  logic [1:0] coef_sel_i = '0;
  logic signed [31:0] coef_value_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CIDX_W-1:0] cell_index_o;
  logic found_o;
  logic walk_limit_hit_o;

  // predictor state: plane words, which words are loaded, and grid frame
  int plane_mem[3][MAX_COUNT*4];
  bit word_set[3][MAX_COUNT*4];
  longint grid_org[3];
  longint unsigned grid_inv[3];

  locate_result_t pending_locates[$];
  int mismatch_count = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  hex_grid_point_locate_walk_top DUT (.*);

  always #1 clk_i = ~clk_i;

  // run limit
  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  // ------------------------------------------------------------------
  // walk predictor
  // ------------------------------------------------------------------
  function automatic int table_count(int t);
    if (t == TBL_YZ) return YZ_COUNT;
    if (t == TBL_XZ) return XZ_COUNT;
    return XY_COUNT;
  endfunction

  function automatic int plane_stride(int t);
    if (t == TBL_YZ) return YZ_STRIDE;
    if (t == TBL_XZ) return XZ_STRIDE;
    return XY_STRIDE;
  endfunction

  // plane number from its own axis position a and the two cross positions
  function automatic int region_plane(int t, int a, int b, int c);
    return a * plane_stride(t) + b * ((t == TBL_YZ) ? CELLS_Y : CELLS_X) + c;
  endfunction

  function automatic bit plane_ready(int t, int k);
    for (int j = 0; j < 4; j++)
      if (!word_set[t][k*4+j]) return 1'b0;
    return 1'b1;
  endfunction

  // all six faces of a cell are loaded
  function automatic bit cell_ready(int ex, int ey, int ez);
    int e;
    e = ex * YZ_STRIDE + ez * CELLS_Y + ey;
    if (!plane_ready(TBL_YZ, e) || !plane_ready(TBL_YZ, e + YZ_STRIDE)) return 1'b0;
    e = ey * XZ_STRIDE + ez * CELLS_X + ex;
    if (!plane_ready(TBL_XZ, e) || !plane_ready(TBL_XZ, e + XZ_STRIDE)) return 1'b0;
    e = ez * XY_STRIDE + ey * CELLS_X + ex;
    if (!plane_ready(TBL_XY, e) || !plane_ready(TBL_XY, e + XY_STRIDE)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit guess_cell(longint pos, longint org, longint unsigned inv,
                                    int cells, output int c);
    longint unsigned d, q;
    c = 0;
    if (pos < org) return 1'b0;
    d = pos - org;
    q = (d * inv) >> 32;
    if (q >= cells) return 1'b0;
    c = int'(q);
    return 1'b1;
  endfunction

  // amount by which the point lies on the wrong side of one face
  function automatic logic signed [127:0] face_excess(int t, int k, longint p[3], bit high);
    logic signed [127:0] np, off;
    longint a;
    np = 0;
    for (int j = 0; j < 3; j++) begin
      a = longint'(plane_mem[t][k*4+j]) * p[j];
      np = np + a;
    end
    a = longint'(plane_mem[t][k*4+WORD_OFFSET]) * 65536;
    off = a;
    if (high) return (np > off) ? np - off : 0;
    return (off > np) ? off - np : 0;
  endfunction

  // expected result in r; returns 0 when the walk would read an unloaded plane
  function automatic bit locate_point(logic signed [31:0] px,
                                      logic signed [31:0] py,
                                      logic signed [31:0] pz,
                                      output locate_result_t r);
    longint p[3];
    int ex, ey, ez, e, steps;
    logic signed [127:0] best, v;
    side_e side;
    bit ok;
    r = '0;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    ok = guess_cell(p[0], grid_org[0], grid_inv[0], CELLS_X, ex);
    if (ok) ok = guess_cell(p[1], grid_org[1], grid_inv[1], CELLS_Y, ey);
    if (ok) ok = guess_cell(p[2], grid_org[2], grid_inv[2], CELLS_Z, ez);
    if (!ok) return 1'b1;
    steps = 0;
    forever begin
      if (!cell_ready(ex, ey, ez)) return 1'b0;
      best = 0;
      side = SIDE_NONE;
      e = ex * YZ_STRIDE + ez * CELLS_Y + ey;
      v = face_excess(TBL_YZ, e, p, 1'b0);
      if (v > best) begin best = v; side = SIDE_XMIN; end
      v = face_excess(TBL_YZ, e + YZ_STRIDE, p, 1'b1);
      if (v > best) begin best = v; side = SIDE_XMAX; end
      e = ey * XZ_STRIDE + ez * CELLS_X + ex;
      v = face_excess(TBL_XZ, e, p, 1'b0);
      if (v > best) begin best = v; side = SIDE_YMIN; end
      v = face_excess(TBL_XZ, e + XZ_STRIDE, p, 1'b1);
      if (v > best) begin best = v; side = SIDE_YMAX; end
      e = ez * XY_STRIDE + ey * CELLS_X + ex;
      v = face_excess(TBL_XY, e, p, 1'b0);
      if (v > best) begin best = v; side = SIDE_ZMIN; end
      v = face_excess(TBL_XY, e + XY_STRIDE, p, 1'b1);
      if (v > best) begin best = v; side = SIDE_ZMAX; end

      if (side == SIDE_NONE || steps >= MAX_WALK_STEPS) begin
        r.cell_index = CIDX_W'(ex + ey * CELLS_X + ez * XY_STRIDE);
        r.found = (side == SIDE_NONE);
        r.walk_limit_hit = (side != SIDE_NONE);
        return 1'b1;
      end
      // stepping off the grid ends the walk without a cell
      case (side)
        SIDE_XMIN: if (ex == 0) return 1'b1; else ex--;
        SIDE_XMAX: if (ex == CELLS_X - 1) return 1'b1; else ex++;
        SIDE_YMIN: if (ey == 0) return 1'b1; else ey--;
        SIDE_YMAX: if (ey == CELLS_Y - 1) return 1'b1; else ey++;
        SIDE_ZMIN: if (ez == 0) return 1'b1; else ez--;
        default:   if (ez == CELLS_Z - 1) return 1'b1; else ez++;
      endcase
      steps++;
    end
  endfunction

  // ------------------------------------------------------------------
  // request driver
  // ------------------------------------------------------------------
  task automatic send_request(logic k, logic [1:0] ts, logic [12:0] pi, logic [1:0] cs,
                              logic signed [31:0] cv, logic signed [31:0] px,
                              logic signed [31:0] py, logic signed [31:0] pz,
                              bit no_gap);
    int gap;
    locate_result_t want;
    @(negedge clk_i);
    kind_i = k;
    table_sel_i = ts;
    plane_index_i = pi;
    coef_sel_i = cs;
    coef_value_i = cv;
    pos_x_i = px;
    pos_y_i = py;
    pos_z_i = pz;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (k == KIND_LOCATE) begin
      void'(locate_point(px, py, pz, want));
      pending_locates.push_back(want);
    end else if (ts != 2'd3 && int'(pi) < table_count(ts)) begin
      plane_mem[ts][int'(pi)*4+cs] = cv;
      word_set[ts][int'(pi)*4+cs] = 1'b1;
    end
    gap = (no_gap || quiet) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // points whose walk would touch an unloaded plane are not sent
  task automatic send_locate(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
    locate_result_t want;
    if (locate_point(px, py, pz, want))
      send_request(KIND_LOCATE, 2'($urandom_range(0, 3)), 13'($urandom), 2'($urandom),
                   32'($urandom), px, py, pz, 1'b0);
  endtask

  task automatic load_plane(logic [1:0] ts, int k, int n0, int n1, int n2, int d,
                            bit no_gap);
    send_request(KIND_LOAD, ts, 13'(k), 2'd0, n0, $urandom, $urandom, $urandom, no_gap);
    send_request(KIND_LOAD, ts, 13'(k), 2'd1, n1, $urandom, $urandom, $urandom, no_gap);
    send_request(KIND_LOAD, ts, 13'(k), 2'd2, n2, $urandom, $urandom, $urandom, no_gap);
    send_request(KIND_LOAD, ts, 13'(k), WORD_OFFSET, d, $urandom, $urandom, $urandom,
                 no_gap);
  endtask

  // axis-aligned face of the undeformed grid, offset shifted by jitter
  task automatic load_regular_plane(logic [1:0] ts, int k, int jitter, bit no_gap);
    int f;
    f = k / plane_stride(ts);
    load_plane(ts, k, (ts == TBL_YZ) ? ONE : 0, (ts == TBL_XZ) ? ONE : 0,
               (ts == TBL_XY) ? ONE : 0, f * ONE + jitter, no_gap);
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_locates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_grid_frame(longint ox, longint oy, longint oz,
                                longint unsigned ix, longint unsigned iy,
                                longint unsigned iz);
    logic [31:0] vals[6];
    settle_block();
    vals = '{ox[31:0], oy[31:0], oz[31:0], ix[31:0], iy[31:0], iz[31:0]};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk_i);
      cfg_we_i = 1'b1;
      cfg_idx_i = CFG_IDX_W'(i);
      cfg_data_i = vals[i];
      @(posedge clk_i);
      if (i < 3) grid_org[i] = longint'($signed(vals[i]));
      else grid_inv[i-3] = vals[i];
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // result monitor and output stall
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    locate_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_locates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: cell %0d found %0b limit %0b",
                   cell_index_o, found_o, walk_limit_hit_o);
      end else begin
        want = pending_locates.pop_front();
        if (cell_index_o !== want.cell_index || found_o !== want.found ||
            walk_limit_hit_o !== want.walk_limit_hit) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: cell %0d/%0d found %0b/%0b limit %0b/%0b (exp/act)",
                     want.cell_index, cell_index_o, want.found, found_o,
                     want.walk_limit_hit, walk_limit_hit_o);
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 11);
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (stall_left > 0);
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  task automatic test_fill_grid();
    for (int t = 0; t < 3; t++)
      for (int a = 0; a <= REGION; a++)
        for (int b = 0; b < REGION; b++)
          for (int c = 0; c < REGION; c++)
            load_regular_plane(2'(t), region_plane(t, a, b, c),
                               int'($urandom_range(0, 16'h3000)) - 16'h1800, 1'b1);
  endtask

  task automatic test_directed_points();
    send_locate(ONE / 2, ONE / 2, ONE / 2);
    send_locate(3 * ONE + ONE / 2, 3 * ONE + ONE / 2, 3 * ONE + ONE / 2);
    send_locate(2 * ONE + 3, ONE, 3 * ONE + 40000);
    // below origin on the x and y axes
    send_locate(-1, ONE, ONE);
    send_locate(ONE, 32'sh8000_0000, ONE);
    // guess beyond the grid
    send_locate(ONE, ONE, 32'sh7fff_ffff);
    send_locate(16 * ONE, ONE, ONE);
    // ignored loads: bad table and index past the table end
    send_request(KIND_LOAD, 2'd3, 13'd5, 2'd3, 32'sh7fff_ffff, 0, 0, 0, 1'b0);
    send_request(KIND_LOAD, TBL_YZ, 13'd8191, 2'd0, 32'sh8000_0000, 0, 0, 0, 1'b0);
    send_request(KIND_LOAD, TBL_XY, 13'(XY_COUNT), 2'd1, 0, 0, 0, 0, 1'b0);
    send_locate(ONE / 2, ONE / 2, ONE / 2);
  endtask

  task automatic test_leave_grid();
    // shifted origin puts the guess inside the grid while the point lies outside
    set_grid_frame(-ONE, 0, 0, 65536, 65536, 65536);
    send_locate(-ONE / 2, 3 * ONE, 3 * ONE);
    set_grid_frame(0, 0, -2 * ONE, 65536, 65536, 65536);
    send_locate(ONE, ONE, -ONE / 4);
    set_grid_frame(0, 0, 0, 65536, 65536, 65536);
  endtask

  task automatic test_walk_limit();
    // four faces around cells (0,0),(1,0),(1,1),(0,1) at z 0 that send the
    // walk round in a loop
    load_plane(TBL_YZ, 1 * YZ_STRIDE + 0, ONE, 0, 0, 0, 1'b0);
    load_plane(TBL_XZ, 1 * XZ_STRIDE + 1, 0, ONE, 0, 0, 1'b0);
    load_plane(TBL_YZ, 1 * YZ_STRIDE + 1, ONE, 0, 0, 100 * ONE, 1'b0);
    load_plane(TBL_XZ, 1 * XZ_STRIDE + 0, 0, ONE, 0, 100 * ONE, 1'b0);
    send_locate(ONE / 2, ONE / 2, ONE / 2);
    settle_block();
    load_regular_plane(TBL_YZ, 1 * YZ_STRIDE + 0, 0, 1'b0);
    load_regular_plane(TBL_XZ, 1 * XZ_STRIDE + 1, 0, 1'b0);
    load_regular_plane(TBL_YZ, 1 * YZ_STRIDE + 1, 0, 1'b0);
    load_regular_plane(TBL_XZ, 1 * XZ_STRIDE + 0, 0, 1'b0);
  endtask

  task automatic test_frame_extremes();
    set_grid_frame(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1, 1, 1);
    send_locate(32'sh7fff_ffff, 0, 32'sh8000_0000);
    send_locate(ONE, ONE, ONE);
    send_locate(ONE / 2, ONE / 2, ONE / 2);
    set_grid_frame(32'sh7fff_ffff, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_locate(32'sh7fff_ffff, 0, 0);
    send_locate(ONE, 0, 0);
    set_grid_frame(0, 0, 0, 32'hffff_ffff, 1, 65536);
    send_locate(ONE / 2 - 1, 32'sh7fff_ffff, 5 * ONE);
  endtask

  task automatic random_point(output logic signed [31:0] c);
    if ($urandom_range(0, 9) == 0) c = $urandom;
    else c = int'($urandom_range(0, 6 * ONE)) - ONE;
  endtask

  task automatic test_random_walks(int count);
    logic signed [31:0] px, py, pz;
    locate_result_t want;
    int pick, t, a;
    bit ok;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == count / 2) settle_block();
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        ok = 1'b0;
        for (int n = 0; n < DRAW_TRIES && !ok; n++) begin
          random_point(px);
          random_point(py);
          random_point(pz);
          ok = locate_point(px, py, pz, want);
        end
        if (ok) send_locate(px, py, pz);
      end else if (pick < 92) begin
        // reshape faces of the loaded block
        t = $urandom_range(0, 2);
        a = $urandom_range(0, REGION);
        send_request(KIND_LOAD, 2'(t),
                     13'(region_plane(t, a, $urandom_range(0, REGION - 1),
                                      $urandom_range(0, REGION - 1))),
                     WORD_OFFSET, a * ONE + (int'($urandom_range(0, 16'h2000)) - 16'h1000),
                     0, 0, 0, 1'b0);
        send_request(KIND_LOAD, 2'(t),
                     13'(region_plane(t, $urandom_range(0, REGION),
                                      $urandom_range(0, REGION - 1),
                                      $urandom_range(0, REGION - 1))),
                     2'($urandom), int'($urandom_range(0, 16'h2000)) - 16'h1000,
                     0, 0, 0, 1'b0);
      end else begin
        send_request(KIND_LOAD, 2'd3, 13'($urandom), 2'($urandom), 32'($urandom),
                     32'($urandom), 32'($urandom), 32'($urandom), 1'b0);
        send_request(KIND_LOAD, 2'($urandom_range(0, 2)),
                     13'($urandom_range(XY_COUNT, 8191)), 2'($urandom), 32'($urandom),
                     32'($urandom), 32'($urandom), 32'($urandom), 1'b0);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_scrambled_planes(int count);
    logic signed [31:0] px, py, pz;
    locate_result_t want;
    int t;
    bit ok;
    for (int i = 0; i < count; i++) begin
      t = $urandom_range(0, 2);
      send_request(KIND_LOAD, 2'(t),
                   13'(region_plane(t, $urandom_range(0, REGION),
                                    $urandom_range(0, REGION - 1),
                                    $urandom_range(0, REGION - 1))),
                   2'($urandom),
                   ($urandom_range(0, 1) == 0) ? int'($urandom) :
                   int'($urandom_range(0, 20 * ONE)) - 2 * ONE,
                   32'($urandom), 32'($urandom), 32'($urandom), 1'b0);
      if (i % 3 == 0) begin
        ok = 1'b0;
        for (int n = 0; n < DRAW_TRIES && !ok; n++) begin
          px = int'($urandom_range(0, REGION * ONE - 1));
          py = int'($urandom_range(0, REGION * ONE - 1));
          pz = int'($urandom_range(0, REGION * ONE - 1));
          ok = locate_point(px, py, pz, want);
        end
        if (ok) send_locate(px, py, pz);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------
  initial begin
    grid_org = '{0, 0, 0};
    grid_inv = '{65536, 65536, 65536};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_grid();
    test_directed_points();
    test_walk_limit();
    test_leave_grid();
    test_frame_extremes();
    set_grid_frame(0, 0, 0, 65536, 65536, 65536);
    test_random_walks(200);
    set_grid_frame(ONE / 7, -ONE / 3, ONE / 5, 58000, 73000, 65536);
    test_random_walks(180);
    set_grid_frame(-ONE / 2, ONE / 4, -ONE / 3, 70000, 52000, 80000);
    test_random_walks(180);
    set_grid_frame(0, 0, 0, 65536, 65536, 65536);
    test_scrambled_planes(120);
    settle_block();

    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- hex_grid_point_locate_walk_top.f -----
rtl/hgpl_pkg.sv
rtl/hex_grid_point_locate_walk_top.sv
rtl/hgpl_checker.sv
tb/sv/tb.sv
